### rtl/core/scan_linear_resampler_assert.svh
`ifndef SCAN_LINEAR_RESAMPLER_ASSERT_SVH
`define SCAN_LINEAR_RESAMPLER_ASSERT_SVH

// same-cycle implication, reset masks the check
`define SLR_ASSERT_NOW(name, clk_s, rstn_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("slr check failed");

// next-cycle implication, reset masks the check
`define SLR_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("slr check failed");

`endif

### rtl/core/slr_pkg.sv
package slr_pkg;

  localparam int STEP_W      = 16;
  localparam int DATA_W      = 16;
  localparam int IDX_W       = 14;
  localparam int MAX_RESULTS = 8;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [STEP_W-1:0] STEP_RESET = 16'd5793;

  typedef struct packed {
    logic                     ray_valid;
    logic [DATA_W-1:0]        range_reading;
    logic signed [DATA_W-1:0] ray_angle;
    logic                     last_ray;
  } slr_in_t;

  typedef struct packed {
    logic                     out_valid;
    logic [DATA_W-1:0]        out_range;
    logic signed [DATA_W-1:0] out_angle;
    logic [IDX_W-1:0]         sample_index;
    logic                     run_last;
    logic                     scan_end;
  } slr_out_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic sum;
    logic adv;
    logic finish;
  } slr_cmd_t;

  typedef struct packed {
    logic emit;
    logic more;
  } slr_status_t;

endpackage

### rtl/core/scan_linear_resampler.sv
// scan_linear_resampler: an accepted item passes states EVAL and SUM, then its first
// result is offered in OUT; each further result of the same item repeats EVAL, SUM,
// OUT once the previous one is taken. an item with no result frees in_ready from EVAL.
// one item is in flight at a time; a new item waits until its last result is taken.
// the rate is set by the evaluate / multiply / sum sequence of the shared datapath.
// rst_n is synchronous, active low: scan state clears and the step returns to 5793.
module scan_linear_resampler
  import slr_pkg::*;
#(
  parameter int MAX_RAYS       = 4096,
  parameter int STEP_FRAC_BITS = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [STEP_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  slr_in_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output slr_out_t          out_data
);

  slr_cmd_t    cmd;
  slr_status_t status;

  assign cfg_ready = 1'b1;

  slr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  slr_dp #(
    .MAX_RAYS       (MAX_RAYS),
    .STEP_FRAC_BITS (STEP_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

### rtl/core/slr_ctrl.sv
module slr_ctrl
  import slr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output slr_cmd_t    cmd,
  input  slr_status_t status
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_SUM  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (status.emit) begin
          cmd.eval  = 1'b1;
          state_nxt = ST_SUM;
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          cmd.adv = 1'b1;
          if (status.more) begin
            state_nxt = ST_EVAL;
          end else begin
            cmd.finish = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

endmodule

### rtl/core/slr_dp.sv
module slr_dp
  import slr_pkg::*;
#(
  parameter int MAX_RAYS       = 4096,
  parameter int STEP_FRAC_BITS = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [STEP_W-1:0] cfg_data,
  input  slr_in_t           in_data,
  input  slr_cmd_t          cmd,
  output slr_status_t       status,
  output slr_out_t          out_data
);

  localparam int RCW    = $clog2(MAX_RAYS) + 1;
  localparam int PW_A   = RCW + STEP_FRAC_BITS;
  localparam int POS_W  = ((PW_A > STEP_W) ? PW_A : STEP_W) + 1;
  localparam int PROD_W = DATA_W + STEP_FRAC_BITS;
  localparam logic [STEP_W-1:0] MIN_STEP = STEP_W'(1 << (STEP_FRAC_BITS - 2));
  localparam logic [RCW-1:0]    RAY_LAST = RCW'(MAX_RAYS - 1);

  // configuration and scan state
  logic [STEP_W-1:0]        step_r;
  logic                     prev_valid_r;
  logic [DATA_W-1:0]        prev_range_r;
  logic signed [DATA_W-1:0] prev_angle_r;
  logic [RCW-1:0]           ray_cnt_r;
  logic [POS_W-1:0]         pos_r;
  logic [IDX_W-1:0]         smp_cnt_r;
  logic [CNT_W-1:0]         n_r;

  // per-item and per-sample payload
  slr_in_t                  cur_r;
  logic                     last_r;
  logic [PROD_W-1:0]        rng_prod_r;
  logic [PROD_W-1:0]        ang_prod_r;
  logic                     rng_neg_r;
  logic                     ang_neg_r;
  logic                     sv_r;
  logic signed [DATA_W-1:0] ang_left_r;
  logic                     more_r;
  slr_out_t                 out_r;

  logic [STEP_W-1:0]         eff_step;
  logic [STEP_FRAC_BITS-1:0] frac;
  logic [POS_W-1:0]          lim_i;
  logic [POS_W-1:0]          lim_f;
  logic [POS_W-1:0]          pos_add;
  logic                      interp;
  logic                      emit;
  logic                      more;
  logic signed [DATA_W:0]    rng_d;
  logic signed [DATA_W:0]    ang_d;
  logic [DATA_W:0]           rng_abs;
  logic [DATA_W:0]           ang_abs;
  logic [DATA_W-1:0]         rng_part;
  logic [DATA_W-1:0]         ang_part;
  slr_out_t                  out_nxt;

  assign eff_step = (step_r < MIN_STEP) ? MIN_STEP : step_r;
  // ray bases are whole multiples of one ray, so the fraction is the low bits
  assign frac     = pos_r[STEP_FRAC_BITS-1:0];
  assign lim_i    = POS_W'(ray_cnt_r) << STEP_FRAC_BITS;
  assign lim_f    = POS_W'(RCW'(ray_cnt_r + RCW'(1))) << STEP_FRAC_BITS;
  assign pos_add  = pos_r + POS_W'(eff_step);

  assign interp = (pos_r < lim_i);
  assign emit   = (n_r < CNT_W'(MAX_RESULTS)) &&
                  (interp || (last_r && (pos_r < lim_f)));
  // lookahead so the last result of the item can carry run_last
  assign more   = (CNT_W'(n_r + CNT_W'(1)) < CNT_W'(MAX_RESULTS)) &&
                  ((pos_add < lim_i) || (last_r && (pos_add < lim_f)));

  assign rng_d   = $signed({1'b0, cur_r.range_reading}) - $signed({1'b0, prev_range_r});
  assign ang_d   = $signed({cur_r.ray_angle[DATA_W-1], cur_r.ray_angle}) -
                   $signed({prev_angle_r[DATA_W-1], prev_angle_r});
  assign rng_abs = rng_d[DATA_W] ? (DATA_W+1)'(0) - rng_d : rng_d;
  assign ang_abs = ang_d[DATA_W] ? (DATA_W+1)'(0) - ang_d : ang_d;

  assign rng_part = rng_prod_r[STEP_FRAC_BITS +: DATA_W];
  assign ang_part = ang_prod_r[STEP_FRAC_BITS +: DATA_W];

  always_comb begin
    out_nxt              = '0;
    out_nxt.out_valid    = sv_r;
    out_nxt.sample_index = smp_cnt_r;
    out_nxt.run_last     = !more_r;
    out_nxt.scan_end     = last_r && !more_r;
    if (sv_r) begin
      out_nxt.out_range = rng_neg_r ? prev_range_r - rng_part : prev_range_r + rng_part;
      out_nxt.out_angle = ang_neg_r ? prev_angle_r - $signed(ang_part)
                                    : prev_angle_r + $signed(ang_part);
    end else begin
      out_nxt.out_range = '0;
      out_nxt.out_angle = ang_left_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= STEP_RESET;
      prev_valid_r <= 1'b0;
      prev_range_r <= '0;
      prev_angle_r <= '0;
      ray_cnt_r    <= '0;
      pos_r        <= '0;
      smp_cnt_r    <= '0;
      n_r          <= '0;
    end else begin
      if (cfg_valid) begin
        step_r <= cfg_data;
      end
      if (cmd.load) begin
        n_r <= '0;
      end else if (cmd.adv) begin
        n_r <= n_r + CNT_W'(1);
      end
      // end of item: clear on the last ray, otherwise it becomes the left ray
      if (cmd.finish && last_r) begin
        prev_valid_r <= 1'b0;
        prev_range_r <= '0;
        prev_angle_r <= '0;
        ray_cnt_r    <= '0;
        pos_r        <= '0;
        smp_cnt_r    <= '0;
      end else begin
        if (cmd.adv) begin
          pos_r     <= pos_add;
          smp_cnt_r <= smp_cnt_r + IDX_W'(1);
        end
        if (cmd.finish) begin
          prev_valid_r <= cur_r.ray_valid;
          prev_range_r <= cur_r.range_reading;
          prev_angle_r <= cur_r.ray_angle;
          ray_cnt_r    <= ray_cnt_r + RCW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_r  <= in_data;
      last_r <= in_data.last_ray || (ray_cnt_r >= RAY_LAST);
    end
    if (cmd.eval) begin
      rng_prod_r <= PROD_W'(rng_abs[DATA_W-1:0]) * PROD_W'(frac);
      ang_prod_r <= PROD_W'(ang_abs[DATA_W-1:0]) * PROD_W'(frac);
      rng_neg_r  <= rng_d[DATA_W];
      ang_neg_r  <= ang_d[DATA_W];
      sv_r       <= interp && prev_valid_r && cur_r.ray_valid;
      ang_left_r <= interp ? prev_angle_r : cur_r.ray_angle;
      more_r     <= more;
    end
    if (cmd.sum) begin
      out_r <= out_nxt;
    end
  end

  assign status.emit = emit;
  assign status.more = more_r;
  assign out_data    = out_r;

endmodule

### rtl/core/slr_checker.sv
`include "scan_linear_resampler_assert.svh"

module slr_checker
  import slr_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input slr_out_t out_data
);

  // one item in flight: no new item while a result is pending
  `SLR_ASSERT_NOW(a_no_accept_while_out, clk, rst_n, out_valid, !in_ready)

  // scan end is only ever on the last result of an item
  `SLR_ASSERT_NOW(a_scan_end_run_last, clk, rst_n, out_valid && out_data.scan_end, out_data.run_last)

  // a result that is not the last of its item is followed by another
  `SLR_ASSERT_NEXT(a_run_continues, clk, rst_n, out_valid && out_ready && !out_data.run_last, ##2 out_valid)

  // sample indexes run on by one within an item
  `SLR_ASSERT_NEXT(a_index_step, clk, rst_n, out_valid && out_ready && !out_data.run_last, ##2 (out_data.sample_index == IDX_W'($past(out_data.sample_index, 3) + IDX_W'(1))))

endmodule

bind scan_linear_resampler slr_checker u_slr_checker (.*);
